@@ design/bba_pkg.sv @@
// bba_pkg: shared constants for the bitmap block allocator.
// Holds default sizes, mode and status codes and register indexes.
// No dependencies.
package bba_pkg;

    // Default sizing
    localparam int DEF_MAX_BLOCKS  = 4096;
    localparam int DEF_BLOCK_BYTES = 4096;

    // Bitmap word width
    localparam int MAP_W = 32;

    // Configuration registers
    localparam int        CFG_W          = 13;
    localparam logic [0:0] CFG_TOTAL     = 1'b0;
    localparam logic [0:0] CFG_RESERVED  = 1'b1;
    localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;

    // Item modes
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;

endpackage

@@ design/bitmap_block_allocator_top.sv @@
// bitmap_block_allocator_top: first-fit block allocator over a used-bit map in RAM.
// Init writes one bitmap word per cycle; alloc reads and checks one word per cycle up to the
// last in-range word, or reports full without a scan when no blocks are managed; free shifts
// the address for a power-of-two block size, else multiplies by a reciprocal.
// One word at a time; a new word is taken while the previous result waits.
// Reset: a fill sweep marks every block used; no word taken meanwhile.
module bitmap_block_allocator_top #(
    parameter int MAX_BLOCKS  = bba_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration port
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [bba_pkg::CFG_W-1:0] i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_mode,
    input  logic [31:0]              i_free_address,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [31:0]              o_block_address,
    output logic [12:0]              o_used_count
);

    localparam int MW     = bba_pkg::MAP_W;
    localparam int WORDS  = (MAX_BLOCKS + MW - 1) / MW;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BI_W   = AW + 5;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int TW     = (CNT_W > bba_pkg::CFG_W) ? CNT_W : bba_pkg::CFG_W;
    localparam int BB_LOG = $clog2(BLOCK_BYTES);
    localparam bit BB_POW2 = ((64'd1 << BB_LOG) == 64'(BLOCK_BYTES));

    // Reciprocal for other block sizes: index = (address * REC_M) >> REC_SH
    localparam int          REC_SH = 32 + BB_LOG;
    localparam logic [32:0] REC_M  =
        33'(((64'd1 << REC_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
    localparam logic [16:0] REC_HI = REC_M[32:16];
    localparam logic [15:0] REC_LO = REC_M[15:0];

    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    // State codes
    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FCMP = 3'd4;
    localparam logic [2:0] ST_FCHK = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Bits of word w that lie below limit lim
    function automatic logic [MW-1:0] lt_mask(input logic [TW-1:0] w, input logic [TW-1:0] lim);
        logic [TW-1:0] hi;
        hi = lim >> 5;
        if (w < hi) begin
            lt_mask = '1;
        end else if (w == hi) begin
            lt_mask = (MW'(1) << lim[4:0]) - MW'(1);
        end else begin
            lt_mask = '0;
        end
    endfunction

    // Bits of word w at or above limit lim
    function automatic logic [MW-1:0] ge_mask(input logic [TW-1:0] w, input logic [TW-1:0] lim);
        logic [TW-1:0] hi;
        hi = lim >> 5;
        if (w > hi) begin
            ge_mask = '1;
        end else if (w == hi) begin
            ge_mask = {MW{1'b1}} << lim[4:0];
        end else begin
            ge_mask = '0;
        end
    endfunction

    // Registers
    logic [2:0]                r_state, n_state;
    logic                      r_fill_all, n_fill_all;
    logic [AW-1:0]             r_waddr, n_waddr;
    logic [AW:0]               r_issue, n_issue;
    logic                      r_chk_v, n_chk_v;
    logic [AW-1:0]             r_chk_addr, n_chk_addr;
    logic [31:0]               r_dvd, n_dvd;
    logic                      r_div_ph, n_div_ph;
    logic [48:0]               r_prod_hi, n_prod_hi;
    logic [47:0]               r_prod_lo, n_prod_lo;
    logic [BI_W-1:0]           r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0]          r_used, n_used;
    logic [1:0]                r_res_status, n_res_status;
    logic                      r_res_alloc, n_res_alloc;
    logic [bba_pkg::CFG_W-1:0] r_total, r_reserved;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [31:0]               r_out_addr;
    logic [12:0]               r_out_used;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [MW-1:0] ram_rdata;

    // Derived values
    logic [TW-1:0]   eff_total;
    logic [AW:0]     nwords;
    logic [MW-1:0]   fill_word;
    logic [MW-1:0]   free_bits;
    logic            hit;
    logic [4:0]      hit_bit;
    logic [64:0]     quo_sum;
    logic            out_load;

    assign eff_total = (TW'(r_total) > TW'(MAX_BLOCKS)) ? TW'(MAX_BLOCKS) : TW'(r_total);
    assign nwords    = (AW+1)'((eff_total + TW'(MW - 1)) >> 5);

    // Init word: blocks in [reserved, total) are free, everything else used
    assign fill_word = r_fill_all ? '1 :
        ~(ge_mask(TW'(r_waddr), TW'(r_reserved)) & lt_mask(TW'(r_waddr), eff_total));

    // First free block among the in-range bits of the checked word
    assign free_bits = ~ram_rdata & lt_mask(TW'(r_chk_addr), eff_total);
    assign hit       = r_chk_v && (free_bits != '0);

    always_comb begin
        hit_bit = '0;
        for (int b = MW - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = 5'(b);
            end
        end
    end

    // Reciprocal product, high and low partial products recombined
    assign quo_sum = {r_prod_hi, 16'h0000} + 65'(r_prod_lo);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_fill_all   = r_fill_all;
        n_waddr      = r_waddr;
        n_issue      = r_issue;
        n_chk_v      = 1'b0;
        n_chk_addr   = r_chk_addr;
        n_dvd        = r_dvd;
        n_div_ph     = r_div_ph;
        n_prod_hi    = r_prod_hi;
        n_prod_lo    = r_prod_lo;
        n_hit_idx    = r_hit_idx;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_alloc  = r_res_alloc;
        ram_we       = 1'b0;
        ram_waddr    = r_waddr;
        ram_wdata    = fill_word;
        ram_raddr    = r_issue[AW-1:0];

        unique case (r_state)
            // Write one bitmap word per cycle
            ST_FILL: begin
                ram_we  = 1'b1;
                n_waddr = r_waddr + AW'(1);
                if (r_waddr == LAST_WORD) begin
                    n_state = r_fill_all ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = bba_pkg::STAT_OK;
                    n_res_alloc  = 1'b0;
                    unique case (i_mode)
                        bba_pkg::MODE_INIT: begin
                            n_state    = ST_FILL;
                            n_fill_all = 1'b0;
                            n_waddr    = '0;
                            n_used     = (TW'(r_reserved) < eff_total) ?
                                         CNT_W'(r_reserved) : CNT_W'(eff_total);
                        end
                        bba_pkg::MODE_ALLOC: begin
                            n_issue = '0;
                            if (nwords == '0) begin
                                n_res_status = bba_pkg::STAT_FULL;
                                n_state      = ST_DONE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        bba_pkg::MODE_FREE: begin
                            n_dvd    = i_free_address;
                            n_div_ph = 1'b0;
                            n_state  = ST_DIV;
                        end
                        bba_pkg::MODE_NOP: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            // Pipelined scan: issue a read, check the word read last cycle
            ST_SCAN: begin
                if (hit) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_chk_addr;
                    ram_wdata   = ram_rdata | (MW'(1) << hit_bit);
                    n_hit_idx   = {r_chk_addr, hit_bit};
                    n_res_alloc = 1'b1;
                    if (r_used < CNT_W'(MAX_BLOCKS)) begin
                        n_used = r_used + CNT_W'(1);
                    end
                    n_state = ST_DONE;
                end else if (r_chk_v && ({1'b0, r_chk_addr} == nwords - (AW+1)'(1))) begin
                    n_res_status = bba_pkg::STAT_FULL;
                    n_state      = ST_DONE;
                end else if (r_issue < nwords) begin
                    n_issue    = r_issue + (AW+1)'(1);
                    n_chk_v    = 1'b1;
                    n_chk_addr = r_issue[AW-1:0];
                end
            end
            // Byte address to block index
            ST_DIV: begin
                if (BB_POW2) begin
                    n_dvd   = r_dvd >> BB_LOG;
                    n_state = ST_FCMP;
                end else if (!r_div_ph) begin
                    n_prod_hi = 49'(r_dvd) * 49'(REC_HI);
                    n_prod_lo = 48'(r_dvd) * 48'(REC_LO);
                    n_div_ph  = 1'b1;
                end else begin
                    n_dvd   = 32'(quo_sum >> REC_SH);
                    n_state = ST_FCMP;
                end
            end
            // Range check, read the word holding the block
            ST_FCMP: begin
                ram_raddr = r_dvd[BI_W-1:5];
                if (r_dvd < 32'(eff_total)) begin
                    n_state = ST_FCHK;
                end else begin
                    n_res_status = bba_pkg::STAT_BAD_FREE;
                    n_state      = ST_DONE;
                end
            end
            // Clear the bit if the block is in use
            ST_FCHK: begin
                if (ram_rdata[r_dvd[4:0]]) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dvd[BI_W-1:5];
                    ram_wdata = ram_rdata & ~(MW'(1) << r_dvd[4:0]);
                    if (r_used != '0) begin
                        n_used = r_used - CNT_W'(1);
                    end
                end else begin
                    n_res_status = bba_pkg::STAT_BAD_FREE;
                end
                n_state = ST_DONE;
            end
            // Hand the result to the output register
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_fill_all <= 1'b1;
            r_waddr    <= '0;
            r_chk_v    <= 1'b0;
            r_used     <= CNT_W'(MAX_BLOCKS);
        end else begin
            r_state    <= n_state;
            r_fill_all <= n_fill_all;
            r_waddr    <= n_waddr;
            r_chk_v    <= n_chk_v;
            r_used     <= n_used;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_issue      <= n_issue;
        r_chk_addr   <= n_chk_addr;
        r_dvd        <= n_dvd;
        r_div_ph     <= n_div_ph;
        r_prod_hi    <= n_prod_hi;
        r_prod_lo    <= n_prod_lo;
        r_hit_idx    <= n_hit_idx;
        r_res_status <= n_res_status;
        r_res_alloc  <= n_res_alloc;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= bba_pkg::TOTAL_RST;
            r_reserved <= bba_pkg::RESERVED_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bba_pkg::CFG_TOTAL) begin
                r_total <= i_cfg_data;
            end else begin
                r_reserved <= i_cfg_data;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_alloc ? 32'(32'(r_hit_idx) * 32'(BLOCK_BYTES)) : '0;
            r_out_used   <= 13'(r_used);
        end
    end

    // Bitmap storage
    bba_ram #(
        .WIDTH (MW),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_block_address = r_out_addr;
    assign o_used_count    = r_out_used;

endmodule

@@ design/bba_ram.sv @@
// bba_ram: generic single-write, single-read RAM with registered read.
// Read during a write to the same address returns the old data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ bench/bitmap_block_allocator_top_tb.sv @@
// Self-checking bench for bitmap_block_allocator_top: directed corner cases, then random
// phases of init/alloc/free traffic under changing block limits, with bursty handshakes.
// Depends on bba_pkg and bitmap_block_allocator_top.
`timescale 1ns / 1ps

module bitmap_block_allocator_top_tb;

    localparam int          MAXB        = bba_pkg::DEF_MAX_BLOCKS;
    localparam int          BLK_BYTES   = bba_pkg::DEF_BLOCK_BYTES;
    localparam int          RANDOM_WORDS = 1500;
    localparam int          QUIET_TAIL  = 200;
    localparam int          SETTLE      = 150;
    localparam longint      RUN_LIMIT_NS = 64'd12_000_000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [12:0] used_count;
    } t_reply;

    // Mirror of the allocator: bitmap, used count and limits, plus replies still owed
    class bitmap_tracker;
        localparam int WORDS = (MAXB + 31) / 32;
        bit [31:0]   used_map [WORDS];
        int unsigned used_blocks;
        int unsigned total_reg;
        int unsigned reserved_reg;
        t_reply      pending_results [$];
        int          failures;

        function new();
            foreach (used_map[w]) used_map[w] = '1;
            used_blocks  = MAXB;
            total_reg    = bba_pkg::TOTAL_RST;
            reserved_reg = bba_pkg::RESERVED_RST;
            failures     = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [12:0] val);
            if (idx == bba_pkg::CFG_TOTAL)
                total_reg = val;
            else
                reserved_reg = val;
        endfunction

        // totals above the bitmap size are clipped
        function int unsigned span();
            return (total_reg > MAXB) ? MAXB : total_reg;
        endfunction

        function bit is_used(int unsigned blk);
            return used_map[blk / 32][blk % 32];
        endfunction

        function void note_request(logic [1:0] mode, logic [31:0] addr);
            t_reply      r;
            int unsigned lim;
            int unsigned i;
            int unsigned blk;
            bit          found;
            lim             = span();
            r.status        = bba_pkg::STAT_OK;
            r.block_address = '0;
            case (mode)
                bba_pkg::MODE_INIT: begin
                    // everything used, then release reserved..total-1
                    foreach (used_map[w]) used_map[w] = '1;
                    used_blocks = lim;
                    for (i = reserved_reg; i < lim; i++) begin
                        used_map[i / 32][i % 32] = 1'b0;
                        used_blocks--;
                    end
                end
                bba_pkg::MODE_ALLOC: begin
                    found = 1'b0;
                    for (i = 0; i < lim; i++) begin
                        if (!is_used(i)) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) begin
                        used_map[i / 32][i % 32] = 1'b1;
                        if (used_blocks < MAXB) used_blocks++;
                        r.block_address = 32'(longint'(i) * longint'(BLK_BYTES));
                    end else begin
                        r.status = bba_pkg::STAT_FULL;
                    end
                end
                bba_pkg::MODE_FREE: begin
                    blk = addr / BLK_BYTES;
                    if (blk < lim && is_used(blk)) begin
                        used_map[blk / 32][blk % 32] = 1'b0;
                        if (used_blocks > 0) used_blocks--;
                    end else begin
                        r.status = bba_pkg::STAT_BAD_FREE;
                    end
                end
                default: ;
            endcase
            r.used_count = 13'(used_blocks);
            pending_results.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [31:0] ba, logic [12:0] uc);
            t_reply e;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: status %0d addr %h used %0d", st, ba, uc);
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status || ba !== e.block_address || uc !== e.used_count) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: exp status %0d addr %h used %0d, got %0d %h %0d",
                             e.status, e.block_address, e.used_count, st, ba, uc);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [bba_pkg::CFG_W-1:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [31:0] i_free_address;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [31:0] o_block_address;
    logic [12:0] o_used_count;

    bit            bursty = 1'b1;
    bitmap_tracker tracker = new();

    bitmap_block_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_used_count    (o_used_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("bitmap_block_allocator_top_tb: FAIL");
        $finish;
    end

    // Result side: random stall bursts while bursty is set
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (bursty && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_reply(o_status, o_block_address, o_used_count);
    end

    // Offer one request word, hold it until taken
    task automatic send_request(input logic [1:0] m, input logic [31:0] a);
        if (bursty && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= m;
        i_free_address <= a;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(m, a);
    endtask

    // Drain the block, then write both limit registers
    task automatic load_limits(input int unsigned tot, input int unsigned res);
        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bba_pkg::CFG_TOTAL;
        i_cfg_data <= tot[bba_pkg::CFG_W-1:0];
        @(posedge i_clk);
        tracker.write_reg(bba_pkg::CFG_TOTAL, tot[bba_pkg::CFG_W-1:0]);
        i_cfg_idx  <= bba_pkg::CFG_RESERVED;
        i_cfg_data <= res[bba_pkg::CFG_W-1:0];
        @(posedge i_clk);
        tracker.write_reg(bba_pkg::CFG_RESERVED, res[bba_pkg::CFG_W-1:0]);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned tot;
        int unsigned res;
        int unsigned lim;
        int unsigned blk;
        int unsigned k;
        int unsigned r;
        bit          found;
        logic [1:0]  m;
        logic [31:0] a;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= bba_pkg::CFG_TOTAL;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_mode         <= bba_pkg::MODE_INIT;
        i_free_address <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset: every block used, default limits
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(bba_pkg::MODE_FREE, 32'hFFFF_FFFF);
        send_request(bba_pkg::MODE_NOP, 32'hA5A5_5A5A);
        send_request(bba_pkg::MODE_INIT, 32'h5A5A_A5A5);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'(BLK_BYTES) + 32'(BLK_BYTES - 1));

        // Partial last bitmap word
        load_limits(40, 38);
        send_request(bba_pkg::MODE_INIT, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'(39 * BLK_BYTES));
        send_request(bba_pkg::MODE_FREE, 32'(40 * BLK_BYTES));

        // Oversized total with reserved equal to it, both beyond the bitmap
        load_limits(8191, 8191);
        send_request(bba_pkg::MODE_INIT, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'((MAXB - 1) * BLK_BYTES));
        send_request(bba_pkg::MODE_ALLOC, 32'h0);

        // Nothing managed
        load_limits(0, 0);
        send_request(bba_pkg::MODE_INIT, 32'h0);
        send_request(bba_pkg::MODE_ALLOC, 32'h0);
        send_request(bba_pkg::MODE_FREE, 32'h0);

        // Total raised without a new init: count drifts toward zero
        load_limits(10, 10);
        send_request(bba_pkg::MODE_INIT, 32'h0);
        load_limits(MAXB, 0);
        send_request(bba_pkg::MODE_FREE, 32'(10 * BLK_BYTES));
        send_request(bba_pkg::MODE_FREE, 32'((MAXB - 1) * BLK_BYTES));

        // Random phases, each under its own limits
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0: tot = 0;
                1: tot = 1;
                2: tot = 32;
                3: tot = $urandom_range(33, 63);
                4: tot = MAXB;
                5: tot = $urandom_range(MAXB + 1, 8191);
                6: tot = MAXB - 1;
                default: tot = $urandom_range(2, 200);
            endcase
            case ($urandom_range(0, 5))
                0: res = 0;
                1: res = 1;
                2: res = tot;
                3: res = (tot + $urandom_range(1, 50) > 8191) ? 8191
                                                             : tot + $urandom_range(1, 50);
                4: res = $urandom_range(0, tot);
                default: res = $urandom_range(0, 8191);
            endcase
            load_limits(tot, res);
            // mostly start clean; sometimes keep the old map to let the count drift
            if ($urandom_range(0, 7) != 0) begin
                send_request(bba_pkg::MODE_INIT, $urandom());
                sent++;
            end
            n = $urandom_range(60, 200);
            repeat (n) begin
                if (sent >= RANDOM_WORDS) break;
                if (sent > RANDOM_WORDS - QUIET_TAIL) bursty = 1'b0;
                r = $urandom_range(0, 99);
                a = $urandom();
                if (r < 45) begin
                    m = bba_pkg::MODE_ALLOC;
                end else if (r < 85) begin
                    // free of a block in use, found by a scan from a random start
                    m     = bba_pkg::MODE_FREE;
                    lim   = tracker.span();
                    found = 1'b0;
                    if (lim != 0) begin
                        blk = $urandom_range(0, lim - 1);
                        for (k = 0; k < lim && !found; k++) begin
                            if (tracker.is_used((blk + k) % lim)) begin
                                found = 1'b1;
                                blk   = (blk + k) % lim;
                            end
                        end
                    end
                    if (found)
                        a = 32'(blk * BLK_BYTES) + 32'($urandom_range(0, BLK_BYTES - 1));
                end else if (r < 93) begin
                    m = bba_pkg::MODE_FREE;
                    if (r < 89)
                        a = 32'($urandom_range(0, tracker.span() + 4) * BLK_BYTES);
                end else if (r < 96) begin
                    m = bba_pkg::MODE_NOP;
                end else begin
                    m = bba_pkg::MODE_INIT;
                end
                send_request(m, a);
                sent++;
            end
        end

        // Drain and settle
        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_results.size() == 0)
            $display("bitmap_block_allocator_top_tb: PASS");
        else
            $display("bitmap_block_allocator_top_tb: FAIL");
        $finish;
    end

endmodule

@@ bitmap_block_allocator_top.f @@
design/bba_pkg.sv
design/bba_ram.sv
design/bitmap_block_allocator_top.sv
bench/bitmap_block_allocator_top_tb.sv
